>>> design/rsm_pkg.sv
`default_nettype none

package rsm_pkg;

  // Item kinds carried on the mode field.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Pattern register layout: seven character bytes, length in the top three bits.
  localparam int PAT_W     = 59;
  localparam int PAT_BYTES = 7;
  localparam int LEN_LSB   = 56;
  localparam int LEN_W     = 3;

  // Configuration register indexes.
  localparam int          CFG_IDX_W   = 3;
  localparam logic [2:0]  TIMEOUT_IDX = 3'd7;

  // Reset contents: "OK" CR LF and "ERROR" CR LF, last character in byte 0.
  localparam logic [PAT_W-1:0] PAT_ONE_RESET = 59'h400_0000_4F4B_0D0A;
  localparam logic [PAT_W-1:0] PAT_TWO_RESET = 59'h745_5252_4F52_0D0A;

  localparam logic [15:0] DEFAULT_TIMEOUT = 16'd1000;

  // Control from the sequencer to every history cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // One result word.
  typedef struct packed {
    logic       done_res;
    logic [2:0] matched;
    logic       waiting;
  } res_t;

endpackage

`default_nettype wire

>>> design/rsm_cell.sv
`default_nettype none

module rsm_cell import rsm_pkg::*; #(
  parameter int N_PAT = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cell_ctl_t             ctl,
  input  wire logic [7:0]            din,
  input  wire logic                  valid_in,
  input  wire logic [N_PAT-1:0][7:0] pat_byte,
  output logic [7:0]                 dout,
  output logic                       valid_out,
  output logic [N_PAT-1:0]           hit
);

  logic [7:0] byte_r;
  logic       valid_r;
  logic       valid_nxt;

  // The incoming byte is what this cell holds after the shift, so it is
  // compared against this position of every pattern.
  always_comb begin
    for (int p = 0; p < N_PAT; p++) begin
      hit[p] = (din == pat_byte[p]);
    end
  end

  // Valid follows the neighbor on a shift; a start empties the cell.
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Character storage needs no reset; no match uses an empty cell's byte.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= din;
    end
  end

  assign dout      = byte_r;
  assign valid_out = valid_r;

endmodule

`default_nettype wire

>>> design/rsm_outbuf.sv
`default_nettype none

module rsm_outbuf import rsm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_res,
  input  wire logic out_stall,
  output logic      out_valid,
  output res_t      out_res,
  output logic      full
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic take;

  assign take = out_valid_r & ~out_stall;

  // Output register backed by one skid word. A push only comes while the
  // skid word is empty.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (take) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!out_valid_r || (take && !skid_valid_r)) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = push_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign full      = skid_valid_r;

endmodule

`default_nettype wire

>>> design/response_suffix_matcher_unit.sv
// Reply matcher for a serial modem link.
// Input channel (in_valid / in_stall): one word per item. in_mode selects
// start a wait, received byte (in_rx_byte) or one millisecond tick.
// Result channel (out_valid / out_stall): exactly one word per input word,
// in order: out_done_res, out_matched (pattern 1..N, 0 on timeout) and
// out_waiting.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at the clock
// edge: indexes 0..6 are the reply patterns, index 7 the timeout in ms.
// Each result word is registered in the output register, or in the skid
// word while the output word is held. One item is taken every cycle while
// in_stall is low. The history is a row of byte cells that shifts on every
// stored byte; all pattern compares finish in the accepting cycle.
// The output register has one skid word behind it, so an item is still
// taken while one result waits; in_stall rises only when both are full.
// Reset (rst_n low at a clock edge) loads the default patterns "OK" CR LF
// and "ERROR" CR LF, a 1000 ms timeout, closes any wait and drops results.
`default_nettype none

module response_suffix_matcher_unit import rsm_pkg::*; #(
  parameter int PATTERN_CHARS = 7,
  parameter int PATTERN_COUNT = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_mode,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_done_res,
  output logic [2:0]                out_matched,
  output logic                      out_waiting,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PAT_W-1:0]     cfg_wdata
);

  localparam int CNT_W = 4;

  logic [PAT_W-1:0] pat_r [PATTERN_COUNT];
  logic [15:0]      timeout_r;
  logic             running_r, running_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;

  logic      accept;
  logic      buf_full;
  cell_ctl_t ctl;
  res_t      res;
  res_t      out_res;

  logic [PATTERN_CHARS-1:0][7:0]                    cell_din;
  logic [PATTERN_CHARS-1:0][7:0]                    cell_dout;
  logic [PATTERN_CHARS-1:0]                         cell_vin;
  logic [PATTERN_CHARS-1:0]                         cell_vout;
  logic [PATTERN_CHARS-1:0][PATTERN_COUNT-1:0]      cell_hit;
  logic [PATTERN_CHARS-1:0][PATTERN_COUNT-1:0][7:0] cell_pat;

  logic [PATTERN_COUNT-1:0] pat_hit;
  logic [2:0]               first_hit;
  logic [15:0]              elapsed_inc;
  logic [15:0]              limit;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = buf_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PATTERN_COUNT; p++) begin
        pat_r[p] <= (p == 0) ? PAT_ONE_RESET : ((p == 1) ? PAT_TWO_RESET : '0);
      end
      timeout_r <= DEFAULT_TIMEOUT;
    end else if (cfg_we) begin
      for (int p = 0; p < PATTERN_COUNT; p++) begin
        if (cfg_index == CFG_IDX_W'(p)) begin
          pat_r[p] <= cfg_wdata;
        end
      end
      if (cfg_index == TIMEOUT_IDX) begin
        timeout_r <= cfg_wdata[15:0];
      end
    end
  end

  // Cell control: a start empties the row, a stored byte shifts it.
  always_comb begin
    ctl.clear = accept && (in_mode == MODE_START);
    ctl.shift = accept && (in_mode == MODE_BYTE) && running_r && (in_rx_byte != 8'd0);
  end

  // Row of history cells, newest character in cell 0.
  for (genvar k = 0; k < PATTERN_CHARS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_din[k] = in_rx_byte;
      assign cell_vin[k] = 1'b1;
    end else begin : g_link
      assign cell_din[k] = cell_dout[k-1];
      assign cell_vin[k] = cell_vout[k-1];
    end

    for (genvar p = 0; p < PATTERN_COUNT; p++) begin : g_pat
      if (k < PAT_BYTES) begin : g_byte
        assign cell_pat[k][p] = pat_r[p][8*k +: 8];
      end else begin : g_none
        assign cell_pat[k][p] = 8'd0;
      end
    end

    rsm_cell #(
      .N_PAT(PATTERN_COUNT)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .din      (cell_din[k]),
      .valid_in (cell_vin[k]),
      .pat_byte (cell_pat[k]),
      .dout     (cell_dout[k]),
      .valid_out(cell_vout[k]),
      .hit      (cell_hit[k])
    );
  end

  // A pattern matches when its length is nonzero, the row holds at least
  // that many characters after the shift and every cell below it agrees.
  always_comb begin
    logic [LEN_W-1:0] len;
    logic             all_eq;
    logic             filled;
    for (int p = 0; p < PATTERN_COUNT; p++) begin
      len    = pat_r[p][LEN_LSB +: LEN_W];
      all_eq = (len != '0);
      filled = 1'b0;
      for (int k = 0; k < PATTERN_CHARS; k++) begin
        if ({1'b0, len} == CNT_W'(k + 1)) begin
          filled = cell_vin[k];
        end
        if ((CNT_W'(k) < {1'b0, len}) && !cell_hit[k][p]) begin
          all_eq = 1'b0;
        end
      end
      pat_hit[p] = all_eq & filled;
    end
  end

  // Lowest-numbered matching pattern wins.
  always_comb begin
    first_hit = 3'd0;
    for (int p = PATTERN_COUNT - 1; p >= 0; p--) begin
      if (pat_hit[p]) begin
        first_hit = 3'(p + 1);
      end
    end
  end

  // Millisecond count saturates; a zero limit stands for the default.
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign limit       = (timeout_r == 16'd0) ? DEFAULT_TIMEOUT : timeout_r;

  // Wait sequencing and the result word of the accepted item.
  always_comb begin
    running_nxt  = running_r;
    elapsed_nxt  = elapsed_r;
    res.done_res = 1'b0;
    res.matched  = 3'd0;
    unique case (in_mode)
      MODE_START: begin
        running_nxt = 1'b1;
        elapsed_nxt = 16'd0;
      end
      MODE_BYTE: begin
        if (running_r && (in_rx_byte != 8'd0) && (first_hit != 3'd0)) begin
          res.done_res = 1'b1;
          res.matched  = first_hit;
          running_nxt  = 1'b0;
        end
      end
      MODE_TICK: begin
        if (running_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= limit) begin
            res.done_res = 1'b1;
            running_nxt  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    res.waiting = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      elapsed_r <= 16'd0;
    end else if (accept) begin
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  rsm_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_res (res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_res  (out_res),
    .full     (buf_full)
  );

  assign out_done_res = out_res.done_res;
  assign out_matched  = out_res.matched;
  assign out_waiting  = out_res.waiting;

  // The skid word only fills behind a held output word.
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result word on the output");

  // A word that ends the wait never reports the wait as still open.
  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> !out_waiting)
    else $error("finished result still reports waiting");

  // A pattern number is only reported on a finishing word.
  a_match_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_matched != 3'd0)) |-> out_done_res)
    else $error("pattern number without done");

  // A start opens a wait with an empty history row.
  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_START)) |=> (running_r && (cell_vout == '0)))
    else $error("start did not open a clean wait");

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb import rsm_pkg::*; ();

  // Mode 3 carries no meaning; the block must let it pass without effect.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PATTERN_TOTAL = 7;
  localparam int ITEM_GOAL = 600;
  localparam int DRAIN_LIMIT = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_mode;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_done_res;
  logic [2:0]           out_matched;
  logic                 out_waiting;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_wdata;

  int items_sent;
  bit quiet;

  // Tracks the matcher state and holds the reply word each input word must produce.
  class reply_scoreboard;
    logic [PAT_W-1:0] pat [PATTERN_TOTAL];
    logic [15:0]      limit_ms;
    logic [55:0]      history;
    logic [2:0]       fill;
    logic [15:0]      elapsed;
    bit               open;
    res_t             expected_replies[$];
    int               errors;
    int               checked;
    int               hits;
    int               timeouts;
    int               writes;

    function new();
      foreach (pat[i]) pat[i] = '0;
      pat[0]   = PAT_ONE_RESET;
      pat[1]   = PAT_TWO_RESET;
      limit_ms = DEFAULT_TIMEOUT;
      history  = '0;
      fill     = '0;
      elapsed  = '0;
      open     = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [PAT_W-1:0] v);
      writes++;
      if (idx == TIMEOUT_IDX) limit_ms = v[15:0];
      else pat[idx] = v;
    endfunction

    // Lowest-numbered enabled pattern that the history currently ends with.
    function logic [2:0] first_hit();
      int len;
      bit same;
      for (int p = 0; p < PATTERN_TOTAL; p++) begin
        len = pat[p][LEN_LSB +: LEN_W];
        if (len != 0 && len <= fill) begin
          same = 1'b1;
          for (int k = 0; k < len; k++) begin
            if (history[8*k +: 8] != pat[p][8*k +: 8]) same = 1'b0;
          end
          if (same) return 3'(p + 1);
        end
      end
      return 3'd0;
    endfunction

    function void note_item(logic [1:0] mode, logic [7:0] b);
      res_t r;
      logic [15:0] lim;
      r = '0;
      case (mode)
        MODE_START: begin
          history = '0;
          fill    = '0;
          elapsed = '0;
          open    = 1'b1;
        end
        MODE_BYTE: begin
          // Zero bytes are skipped without a compare.
          if (open && b != 8'h00) begin
            history = {history[47:0], b};
            if (fill < 3'd7) fill++;
            r.matched = first_hit();
            if (r.matched != 3'd0) begin
              r.done_res = 1'b1;
              open = 1'b0;
              hits++;
            end
          end
        end
        MODE_TICK: begin
          if (open) begin
            lim = (limit_ms == 16'd0) ? DEFAULT_TIMEOUT : limit_ms;
            if (elapsed != 16'hFFFF) elapsed++;
            if (elapsed >= lim) begin
              r.done_res = 1'b1;
              open = 1'b0;
              timeouts++;
            end
          end
        end
        default: ;
      endcase
      r.waiting = open;
      expected_replies.push_back(r);
    endfunction

    function void check_reply(res_t got);
      res_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result word done_res=%0b matched=%0d waiting=%0b",
                 $time, got.done_res, got.matched, got.waiting);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (got.done_res !== want.done_res) begin
        $display("%0t: done_res expected %0b, actual %0b", $time, want.done_res, got.done_res);
        errors++;
      end
      if (got.matched !== want.matched) begin
        $display("%0t: matched expected %0d, actual %0d", $time, want.matched, got.matched);
        errors++;
      end
      if (got.waiting !== want.waiting) begin
        $display("%0t: waiting expected %0b, actual %0b", $time, want.waiting, got.waiting);
        errors++;
      end
    endfunction

    function void report_leftover();
      if (expected_replies.size() != 0) begin
        $display("%0t: %0d expected result words never arrived, expected %0d, actual 0",
                 $time, expected_replies.size(), expected_replies.size());
        errors++;
      end
    endfunction
  endclass

  reply_scoreboard sb;

  response_suffix_matcher_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_done_res (out_done_res),
    .out_matched  (out_matched),
    .out_waiting  (out_waiting),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin : word_monitor
    res_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.done_res = out_done_res;
        got.matched  = out_matched;
        got.waiting  = out_waiting;
        sb.check_reply(got);
      end
      if (in_valid && !in_stall) sb.note_item(in_mode, in_rx_byte);
    end
  end

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  initial begin : sink_pacing
    int hold;
    int r;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
          hold = $urandom_range(0, 6);
        end else if (r < 93) begin
          out_stall <= 1'b1;
          hold = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(8, 30);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Small alphabet so that random text often ends in a pattern.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0: return 8'h41;
      1: return 8'h42;
      2: return 8'h4F;
      3: return 8'h4B;
      4: return 8'h0D;
      default: return 8'h0A;
    endcase
  endfunction

  // Present one word and hold it until it is taken, then maybe idle.
  task automatic send_word(input logic [1:0] mode, input logic [7:0] b);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [PAT_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop driving input and wait until every expected reply has come out or the drain limit is reached.
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (3) @(negedge clk);
  endtask

  initial begin : stimulus
    int ph;
    int p;
    int k;
    int len;
    int n;
    int r;
    int phase_end;
    logic [15:0] tmo;
    logic [63:0] junk;
    logic [PAT_W-1:0] pv;

    sb = new();
    items_sent = 0;
    quiet      = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = MODE_START;
    in_rx_byte = 8'h00;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Items while idle are ignored, including the unused mode.
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_UNUSED, 8'hA5);
    // Default first pattern, with a zero byte skipped in the middle.
    send_word(MODE_START, 8'h00);
    send_word(MODE_BYTE, 8'h4F);
    send_word(MODE_BYTE, 8'h4B);
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_BYTE, 8'h0D);
    send_word(MODE_BYTE, 8'h0A);
    // Default second pattern, the full seven characters.
    send_word(MODE_START, 8'hFF);
    send_word(MODE_BYTE, 8'h45);
    send_word(MODE_BYTE, 8'h52);
    send_word(MODE_BYTE, 8'h52);
    send_word(MODE_BYTE, 8'h4F);
    send_word(MODE_BYTE, 8'h52);
    send_word(MODE_BYTE, 8'h0D);
    send_word(MODE_BYTE, 8'h0A);
    // A start while waiting restarts; the unused mode leaves the wait open.
    send_word(MODE_START, 8'h00);
    send_word(MODE_BYTE, 8'h41);
    send_word(MODE_START, 8'h00);
    send_word(MODE_UNUSED, 8'h5A);
    send_word(MODE_BYTE, 8'h0A);
    // Short timeout.
    wait_idle();
    program_reg(TIMEOUT_IDX, 59'd2);
    send_word(MODE_START, 8'h00);
    send_ticks(2);

    // Random phases, each with fresh patterns and timeout.
    ph = 0;
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      quiet = (ph % 3 == 2);
      for (p = 0; p < PATTERN_TOTAL; p++) begin
        junk = {$urandom, $urandom};
        if (ph % 5 == 4) begin
          pv = junk[PAT_W-1:0];
        end else if (ph == 3 && p == PATTERN_TOTAL - 1) begin
          pv = '1;
        end else if (ph == 1 || $urandom_range(0, 4) == 0) begin
          pv = {3'd0, junk[55:0]};
        end else begin
          len = (ph == 2) ? 7 : $urandom_range(1, 7);
          pv = {len[2:0], junk[55:0]};
          for (k = 0; k < len; k++) pv[8*k +: 8] = pick_char();
        end
        program_reg(p[2:0], pv);
      end
      case (ph % 4)
        0: tmo = 16'd1;
        1: tmo = 16'($urandom_range(2, 8));
        2: tmo = 16'($urandom_range(9, 40));
        default: tmo = 16'($urandom_range(41, 120));
      endcase
      junk = {$urandom, $urandom};
      program_reg(TIMEOUT_IDX, {junk[42:0], tmo});

      phase_end = items_sent + 50;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 80) begin
          // Well-formed wait: start, some text, then one pattern's characters.
          send_word(MODE_START, 8'($urandom_range(0, 255)));
          n = $urandom_range(0, 4);
          repeat (n) begin
            r = $urandom_range(0, 9);
            if (r == 0) send_word(MODE_BYTE, 8'h00);
            else if (r == 1) send_word(MODE_TICK, 8'($urandom_range(0, 255)));
            else send_word(MODE_BYTE, pick_char());
          end
          p = $urandom_range(0, PATTERN_TOTAL - 1);
          len = sb.pat[p][LEN_LSB +: LEN_W];
          for (k = len - 1; k >= 0; k--) begin
            if ($urandom_range(0, 9) == 0) send_word(MODE_BYTE, 8'h00);
            send_word(MODE_BYTE, sb.pat[p][8*k +: 8]);
          end
          if ($urandom_range(0, 2) == 0)
            send_ticks($urandom_range(1, (tmo < 12) ? tmo + 1 : 12));
        end else begin
          send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
      ph++;
    end

    // Timeout extremes: a zero limit stands for the default and must not end
    // the wait at once, and the largest limit keeps the wait open.
    wait_idle();
    quiet = 1'b1;
    junk = {$urandom, $urandom};
    program_reg(TIMEOUT_IDX, {junk[42:0], 16'd0});
    send_word(MODE_START, 8'h00);
    send_ticks(20);
    wait_idle();
    program_reg(TIMEOUT_IDX, 59'hFFFF);
    send_word(MODE_START, 8'h00);
    send_ticks(20);
    quiet = 1'b0;

    wait_idle();
    sb.report_leftover();
    $display("Checked %0d result words from %0d input words across %0d register writes.",
             sb.checked, items_sent, sb.writes);
    $display("Waits closed by a reply match: %0d, by timeout: %0d.", sb.hits, sb.timeouts);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> response_suffix_matcher_unit.f
design/rsm_pkg.sv
design/rsm_cell.sv
design/rsm_outbuf.sv
design/response_suffix_matcher_unit.sv
test/tb.sv
